// ===== sv/afk_pkg.sv =====
package afk_pkg;

    localparam int NUM_JOINTS   = 6;
    localparam int CORDIC_ITERS = 16;
    localparam int ANG_W        = 16;
    localparam int Q14_W        = 16;
    localparam int CFG_W        = 20;
    localparam int POS_W        = 24;
    localparam int CX_W         = 24;
    localparam int CZ_W         = 18;
    localparam int NUM_ROT      = 9;
    localparam int ADDR_W       = 5;
    localparam int APB_W        = 32;

    localparam logic signed [CX_W-1:0]  CORDIC_START = 24'sd636751;
    localparam logic signed [CZ_W-1:0]  QUARTER_TURN = 18'sd16384;
    localparam logic signed [CZ_W-1:0]  HALF_TURN    = 18'sd32768;
    localparam logic signed [Q14_W-1:0] ROT_LIM      = 16'sd16384;
    localparam logic signed [POS_W-1:0] POS_MAX      = 24'sh7FFFFF;
    localparam logic signed [POS_W-1:0] POS_MIN      = 24'sh800000;

    typedef logic signed [Q14_W-1:0] t_q14;

    typedef struct packed {
        t_q14 [NUM_JOINTS-1:0] sn;
        t_q14 [NUM_JOINTS-1:0] cs;
    } t_trig;

    typedef struct packed {
        logic signed [CFG_W-1:0] shoulder_offset;
        logic signed [CFG_W-1:0] upper_arm_length;
        logic signed [CFG_W-1:0] lateral_offset;
        logic signed [CFG_W-1:0] forearm_length;
        logic signed [CFG_W-1:0] tip_reach;
        logic signed [CFG_W-1:0] mount_height;
    } t_cfg;

    typedef struct packed {
        t_q14 [NUM_ROT-1:0]      rot;
        logic signed [POS_W-1:0] tip_z;
        logic signed [POS_W-1:0] tip_y;
        logic signed [POS_W-1:0] tip_x;
    } t_pose;

    typedef enum logic [2:0] {
        REG_SHOULDER_OFFSET = 3'd0,
        REG_UPPER_ARM       = 3'd1,
        REG_LATERAL         = 3'd2,
        REG_FOREARM         = 3'd3,
        REG_CLAW            = 3'd4,
        REG_BASE_HEIGHT     = 3'd5
    } t_reg_idx;

    function automatic logic signed [CZ_W-1:0] atan_step(input logic [3:0] i);
        logic signed [CZ_W-1:0] a;
        unique case (i)
            4'd0:    a = 18'sd8192;
            4'd1:    a = 18'sd4836;
            4'd2:    a = 18'sd2555;
            4'd3:    a = 18'sd1297;
            4'd4:    a = 18'sd651;
            4'd5:    a = 18'sd326;
            4'd6:    a = 18'sd163;
            4'd7:    a = 18'sd81;
            4'd8:    a = 18'sd41;
            4'd9:    a = 18'sd20;
            4'd10:   a = 18'sd10;
            4'd11:   a = 18'sd5;
            4'd12:   a = 18'sd3;
            4'd13:   a = 18'sd1;
            4'd14:   a = 18'sd1;
            default: a = 18'sd0;
        endcase
        return a;
    endfunction

    function automatic t_q14 sat_q14(input logic signed [63:0] v, input logic [5:0] sh);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< (sh - 6'd1))) >>> sh;
        if (r > 64'sd16384) begin
            return ROT_LIM;
        end else if (r < -64'sd16384) begin
            return -ROT_LIM;
        end
        return t_q14'(r);
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< 27)) >>> 28;
        if (r > 64'sd8388607) begin
            return POS_MAX;
        end else if (r < -64'sd8388608) begin
            return POS_MIN;
        end
        return POS_W'(r);
    endfunction

endpackage

// ===== sv/afk_front.sv =====
module afk_front (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  logic [afk_pkg::NUM_JOINTS-1:0][afk_pkg::ANG_W-1:0] i_angles,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output afk_pkg::t_trig                            o_trig
);
    import afk_pkg::*;

    logic                   w_en;
    logic [CORDIC_ITERS:0]  r_v;
    logic                   r_ov;
    logic signed [CX_W-1:0] r_x    [CORDIC_ITERS+1][NUM_JOINTS];
    logic signed [CX_W-1:0] n_x    [CORDIC_ITERS+1][NUM_JOINTS];
    logic signed [CX_W-1:0] r_y    [CORDIC_ITERS+1][NUM_JOINTS];
    logic signed [CX_W-1:0] n_y    [CORDIC_ITERS+1][NUM_JOINTS];
    logic signed [CZ_W-1:0] r_z    [CORDIC_ITERS+1][NUM_JOINTS];
    logic signed [CZ_W-1:0] n_z    [CORDIC_ITERS+1][NUM_JOINTS];
    logic                   r_flip [CORDIC_ITERS+1][NUM_JOINTS];
    logic                   n_flip [CORDIC_ITERS+1][NUM_JOINTS];
    t_trig                  r_out;
    t_trig                  n_out;

    assign w_en    = !r_ov || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_ov;
    assign o_trig  = r_out;

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            // fold into the right half plane; the half turn flips both results
            n_z[0][j]    = CZ_W'(signed'(i_angles[j]));
            n_flip[0][j] = 1'b0;
            if (n_z[0][j] > QUARTER_TURN) begin
                n_z[0][j]    = n_z[0][j] - HALF_TURN;
                n_flip[0][j] = 1'b1;
            end else if (n_z[0][j] < -QUARTER_TURN) begin
                n_z[0][j]    = n_z[0][j] + HALF_TURN;
                n_flip[0][j] = 1'b1;
            end
            n_x[0][j] = CORDIC_START;
            n_y[0][j] = '0;
            for (int k = 0; k < CORDIC_ITERS; k++) begin
                if (!r_z[k][j][CZ_W-1]) begin
                    n_x[k+1][j] = r_x[k][j] - (r_y[k][j] >>> k);
                    n_y[k+1][j] = r_y[k][j] + (r_x[k][j] >>> k);
                    n_z[k+1][j] = r_z[k][j] - atan_step(4'(k));
                end else begin
                    n_x[k+1][j] = r_x[k][j] + (r_y[k][j] >>> k);
                    n_y[k+1][j] = r_y[k][j] - (r_x[k][j] >>> k);
                    n_z[k+1][j] = r_z[k][j] + atan_step(4'(k));
                end
                n_flip[k+1][j] = r_flip[k][j];
            end
            n_out.cs[j] = sat_q14(64'(r_flip[CORDIC_ITERS][j] ? -r_x[CORDIC_ITERS][j]
                                                              : r_x[CORDIC_ITERS][j]), 6'd6);
            n_out.sn[j] = sat_q14(64'(r_flip[CORDIC_ITERS][j] ? -r_y[CORDIC_ITERS][j]
                                                              : r_y[CORDIC_ITERS][j]), 6'd6);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_v  <= {r_v[CORDIC_ITERS-1:0], i_valid};
            r_ov <= r_v[CORDIC_ITERS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_flip <= n_flip;
            r_out  <= n_out;
        end
    end

endmodule

// ===== sv/afk_queue.sv =====
module afk_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  afk_pkg::t_trig i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output afk_pkg::t_trig o_data
);
    import afk_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_trig            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_ready && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== sv/afk_back.sv =====
module afk_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  afk_pkg::t_trig i_trig,
    input  afk_pkg::t_cfg  i_cfg,
    output logic           o_valid,
    input  logic           i_ready,
    output afk_pkg::t_pose o_pose
);
    import afk_pkg::*;

    localparam int NUM_STAGES = 6;

    logic                  w_en;
    logic [NUM_STAGES-1:0] r_v;
    t_q14                  s [NUM_JOINTS];
    t_q14                  c [NUM_JOINTS];

    logic signed [31:0] r1_pa, r1_pb, r1_c0c1, r1_s0c1;
    logic signed [31:0] r1_c4c5, r1_c4s5, r1_s3s5, r1_s3c5, r1_c3s5, r1_c3c5;
    t_q14               r1_r6_02, r1_r6_10, r1_r6_11, r1_r6_12, r1_r6_22;
    t_q14               r1_s0, r1_c0, r1_s3, r1_c3;
    logic signed [39:0] r1_linx, r1_liny, r1_s1u;

    t_q14               r2_r3 [3][3];
    t_q14               r2_r6 [3][3];
    logic signed [55:0] r2_tx, r2_ty;
    logic signed [39:0] r2_linx, r2_liny, r2_s1u;

    logic signed [31:0] r3_m [3][3][3];
    logic signed [35:0] r3_fx, r3_fy, r3_fz;
    logic signed [55:0] r3_tx, r3_ty;
    logic signed [39:0] r3_linx, r3_liny, r3_s1u;

    t_q14               r4_dir [3][3];
    logic signed [55:0] r4_ax, r4_ay, r4_az;

    t_q14               r5_dir [3][3];
    logic signed [35:0] r5_cx, r5_cy, r5_cz;
    logic signed [55:0] r5_ax, r5_ay, r5_az;

    t_pose              r6_pose;

    assign w_en    = !r_v[NUM_STAGES-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v[NUM_STAGES-1];
    assign o_pose  = r6_pose;

    always_comb begin
        for (int j = 0; j < NUM_JOINTS; j++) begin
            s[j] = i_trig.sn[j];
            c[j] = i_trig.cs[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[NUM_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_pa    <= 32'(c[1]) * 32'(c[2]) - 32'(s[1]) * 32'(s[2]);
            r1_pb    <= 32'(c[1]) * 32'(s[2]) + 32'(s[1]) * 32'(c[2]);
            r1_c0c1  <= 32'(c[0]) * 32'(c[1]);
            r1_s0c1  <= 32'(s[0]) * 32'(c[1]);
            r1_c4c5  <= 32'(c[4]) * 32'(c[5]);
            r1_c4s5  <= 32'(c[4]) * 32'(s[5]);
            r1_s3s5  <= 32'(s[3]) * 32'(s[5]);
            r1_s3c5  <= 32'(s[3]) * 32'(c[5]);
            r1_c3s5  <= 32'(c[3]) * 32'(s[5]);
            r1_c3c5  <= 32'(c[3]) * 32'(c[5]);
            r1_r6_02 <= sat_q14(-(64'(c[3]) * 64'(s[4])), 6'd14);
            r1_r6_10 <= sat_q14(-(64'(s[4]) * 64'(c[5])), 6'd14);
            r1_r6_11 <= sat_q14(64'(s[4]) * 64'(s[5]), 6'd14);
            r1_r6_12 <= -c[4];
            r1_r6_22 <= sat_q14(-(64'(s[3]) * 64'(s[4])), 6'd14);
            r1_s0    <= s[0];
            r1_c0    <= c[0];
            r1_s3    <= s[3];
            r1_c3    <= c[3];
            r1_linx  <= 40'(c[0]) * 40'(i_cfg.shoulder_offset)
                      + 40'(s[0]) * 40'(i_cfg.lateral_offset);
            r1_liny  <= 40'(s[0]) * 40'(i_cfg.shoulder_offset)
                      - 40'(c[0]) * 40'(i_cfg.lateral_offset);
            r1_s1u   <= 40'(s[1]) * 40'(i_cfg.upper_arm_length);

            r2_r3[0][0] <= sat_q14(64'(r1_c0) * 64'(r1_pa), 6'd28);
            r2_r3[0][1] <= sat_q14(-(64'(r1_c0) * 64'(r1_pb)), 6'd28);
            r2_r3[0][2] <= r1_s0;
            r2_r3[1][0] <= sat_q14(64'(r1_s0) * 64'(r1_pa), 6'd28);
            r2_r3[1][1] <= sat_q14(-(64'(r1_s0) * 64'(r1_pb)), 6'd28);
            r2_r3[1][2] <= -r1_c0;
            r2_r3[2][0] <= sat_q14(64'(r1_pb), 6'd14);
            r2_r3[2][1] <= sat_q14(64'(r1_pa), 6'd14);
            r2_r3[2][2] <= '0;
            r2_r6[0][0] <= sat_q14(64'(r1_c3) * 64'(r1_c4c5) - (64'(r1_s3s5) <<< 14), 6'd28);
            r2_r6[0][1] <= sat_q14(-(64'(r1_c3) * 64'(r1_c4s5)) - (64'(r1_s3c5) <<< 14),
                                   6'd28);
            r2_r6[0][2] <= r1_r6_02;
            r2_r6[1][0] <= r1_r6_10;
            r2_r6[1][1] <= r1_r6_11;
            r2_r6[1][2] <= r1_r6_12;
            r2_r6[2][0] <= sat_q14(64'(r1_s3) * 64'(r1_c4c5) + (64'(r1_c3s5) <<< 14), 6'd28);
            r2_r6[2][1] <= sat_q14(-(64'(r1_s3) * 64'(r1_c4s5)) + (64'(r1_c3c5) <<< 14),
                                   6'd28);
            r2_r6[2][2] <= r1_r6_22;
            r2_tx       <= 56'(r1_c0c1) * 56'(i_cfg.upper_arm_length);
            r2_ty       <= 56'(r1_s0c1) * 56'(i_cfg.upper_arm_length);
            r2_linx     <= r1_linx;
            r2_liny     <= r1_liny;
            r2_s1u      <= r1_s1u;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        r3_m[i][j][k] <= 32'(r2_r3[i][k]) * 32'(r2_r6[k][j]);
                    end
                end
            end
            r3_fx   <= 36'(r2_r3[0][1]) * 36'(i_cfg.forearm_length);
            r3_fy   <= 36'(r2_r3[1][1]) * 36'(i_cfg.forearm_length);
            r3_fz   <= 36'(r2_r3[2][1]) * 36'(i_cfg.forearm_length);
            r3_tx   <= r2_tx;
            r3_ty   <= r2_ty;
            r3_linx <= r2_linx;
            r3_liny <= r2_liny;
            r3_s1u  <= r2_s1u;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r4_dir[i][j] <= sat_q14(64'(r3_m[i][j][0]) + 64'(r3_m[i][j][1])
                                          + 64'(r3_m[i][j][2]), 6'd14);
                end
            end
            r4_ax <= r3_tx + ((56'(r3_linx) - 56'(r3_fx)) <<< 14);
            r4_ay <= r3_ty + ((56'(r3_liny) - 56'(r3_fy)) <<< 14);
            r4_az <= ((56'(r3_s1u) - 56'(r3_fz)) <<< 14) + (56'(i_cfg.mount_height) <<< 28);

            r5_dir <= r4_dir;
            r5_cx  <= 36'(r4_dir[0][2]) * 36'(i_cfg.tip_reach);
            r5_cy  <= 36'(r4_dir[1][2]) * 36'(i_cfg.tip_reach);
            r5_cz  <= 36'(r4_dir[2][2]) * 36'(i_cfg.tip_reach);
            r5_ax  <= r4_ax;
            r5_ay  <= r4_ay;
            r5_az  <= r4_az;

            r6_pose.tip_x <= sat_pos(64'(r5_ax) + (64'(r5_cx) <<< 14));
            r6_pose.tip_y <= sat_pos(64'(r5_ay) + (64'(r5_cy) <<< 14));
            r6_pose.tip_z <= sat_pos(64'(r5_az) + (64'(r5_cz) <<< 14));
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r6_pose.rot[3*i+j] <= r5_dir[i][j];
                end
            end
        end
    end

endmodule

// ===== sv/arm_forward_kinematics_core.sv =====
// Six-axis arm forward kinematics. Each input word carries six joint angles
// (binary angle units, 65536 per turn); each output word carries the tool tip
// position (signed integer in link-length units, saturated) and the tool
// orientation matrix (Q1.14). One word is accepted per clock while the input
// is not stalled, and results leave in input order, one per clock while the
// output is taken. An accepted word passes the sine/cosine unit (angle fold,
// sixteen CORDIC iterations, rounding), the queue and the matrix and position
// pipeline. The two halves stall independently through a queue of
// QUEUE_DEPTH entries. Link lengths are set through the register port at byte
// addresses 0x00..0x14, 20-bit signed, and must only change while idle.
module arm_forward_kinematics_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // joint_angle_0 .. joint_angle_5, 16 bits each
    input  logic [95:0]                  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tip_x, tip_y, tip_z (24 bits each), rot_00 .. rot_22 (16 bits each)
    output logic [215:0]                 m_axis_tdata,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [afk_pkg::ADDR_W-1:0]   paddr,
    input  logic [afk_pkg::APB_W-1:0]    pwdata,
    output logic [afk_pkg::APB_W-1:0]    prdata,
    output logic                         pready
);
    import afk_pkg::*;

    t_cfg                              r_cfg;
    t_reg_idx                          w_idx;
    logic                              w_wr;
    logic [NUM_JOINTS-1:0][ANG_W-1:0]  w_angles;
    logic                              w_f_valid;
    logic                              w_f_ready;
    t_trig                             w_f_trig;
    logic                              w_q_valid;
    logic                              w_q_ready;
    t_trig                             w_q_trig;
    t_pose                             w_pose;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SHOULDER_OFFSET: r_cfg.shoulder_offset  <= pwdata[CFG_W-1:0];
                REG_UPPER_ARM:       r_cfg.upper_arm_length <= pwdata[CFG_W-1:0];
                REG_LATERAL:         r_cfg.lateral_offset   <= pwdata[CFG_W-1:0];
                REG_FOREARM:         r_cfg.forearm_length   <= pwdata[CFG_W-1:0];
                REG_CLAW:            r_cfg.tip_reach        <= pwdata[CFG_W-1:0];
                REG_BASE_HEIGHT:     r_cfg.mount_height     <= pwdata[CFG_W-1:0];
                default:             r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_SHOULDER_OFFSET: prdata = APB_W'(r_cfg.shoulder_offset);
            REG_UPPER_ARM:       prdata = APB_W'(r_cfg.upper_arm_length);
            REG_LATERAL:         prdata = APB_W'(r_cfg.lateral_offset);
            REG_FOREARM:         prdata = APB_W'(r_cfg.forearm_length);
            REG_CLAW:            prdata = APB_W'(r_cfg.tip_reach);
            REG_BASE_HEIGHT:     prdata = APB_W'(r_cfg.mount_height);
            default:             prdata = '0;
        endcase
    end

    assign w_angles = s_axis_tdata;

    afk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_angles (w_angles),
        .o_valid  (w_f_valid),
        .i_ready  (w_f_ready),
        .o_trig   (w_f_trig)
    );

    afk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_trig),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_trig)
    );

    afk_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .o_ready (w_q_ready),
        .i_trig  (w_q_trig),
        .i_cfg   (r_cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_pose  (w_pose)
    );

    assign m_axis_tdata = {w_pose.rot, w_pose.tip_z, w_pose.tip_y, w_pose.tip_x};

endmodule

// ===== sv/afk_checker.sv =====
module afk_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [215:0] m_axis_tdata,
    input logic         psel,
    input logic         penable,
    input logic         pwrite,
    input logic [4:0]   paddr,
    input logic [31:0]  pwdata,
    input logic [31:0]  prdata,
    input logic         pready
);
    import afk_pkg::*;

    logic w_rot_ok;

    always_comb begin
        w_rot_ok = 1'b1;
        for (int k = 0; k < NUM_ROT; k++) begin
            if ($signed(m_axis_tdata[72+16*k +: 16]) > ROT_LIM
                || $signed(m_axis_tdata[72+16*k +: 16]) < -ROT_LIM) begin
                w_rot_ok = 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_rot_ok)
        else $error("orientation entry out of range");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && paddr == 5'd16 ##1 paddr == 5'd16 && !pwrite
        |-> prdata[19:0] == $past(pwdata[19:0]) && prdata[31:20] == {12{prdata[19]}})
        else $error("register readback mismatch");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable |-> pready)
        else $error("register access stalled");

endmodule

bind arm_forward_kinematics_core afk_checker u_afk_checker (.*);

// ===== dv/arm_forward_kinematics_checker.sv =====
`timescale 1ns / 100ps

module arm_forward_kinematics_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [215:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           o_errors,
    output int           o_pending
);
    import afk_pkg::*;

    localparam longint UNIT = 16384;

    longint link_len [6];
    t_pose  pose_q [$];
    int     word_cnt;

    function automatic longint q14_of(longint v, int sh);
        longint r;
        r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r;
    endfunction

    function automatic longint pos_of(longint v);
        longint r;
        r = (v + (64'sd1 <<< 27)) >>> 28;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r;
    endfunction

    function automatic longint arctan_units(int i);
        case (i)
            0: return 8192;    1: return 4836;  2: return 2555;  3: return 1297;
            4: return 651;     5: return 326;   6: return 163;   7: return 81;
            8: return 41;      9: return 20;    10: return 10;   11: return 5;
            12: return 3;      13: return 1;    14: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic void joint_trig(input logic [15:0] ang, output longint sn,
                                       output longint cs);
        longint z, x, y, dx, dy;
        bit     flip;
        z = longint'($signed(ang));
        x = 636751;
        y = 0;
        flip = 0;
        if (z > 16384) begin
            z -= 32768;
            flip = 1;
        end else if (z < -16384) begin
            z += 32768;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= arctan_units(i);
            end else begin
                x += dx;
                y -= dy;
                z += arctan_units(i);
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = q14_of(x, 6);
        sn = q14_of(y, 6);
    endfunction

    function automatic t_pose tool_pose(logic [95:0] angles);
        longint s [6], c [6], r3 [3][3], r6 [3][3], tool [3][3], acc, px, py, pz;
        t_pose  p;
        for (int i = 0; i < 6; i++) joint_trig(angles[16*i +: 16], s[i], c[i]);
        r3[0][0] = q14_of(c[0]*c[1]*c[2] - c[0]*s[1]*s[2], 28);
        r3[0][1] = q14_of(-c[0]*c[1]*s[2] - c[0]*s[1]*c[2], 28);
        r3[0][2] = s[0];
        r3[1][0] = q14_of(s[0]*c[1]*c[2] - s[0]*s[1]*s[2], 28);
        r3[1][1] = q14_of(-s[0]*c[1]*s[2] - s[0]*s[1]*c[2], 28);
        r3[1][2] = -c[0];
        r3[2][0] = q14_of(s[1]*c[2] + c[1]*s[2], 14);
        r3[2][1] = q14_of(-s[1]*s[2] + c[1]*c[2], 14);
        r3[2][2] = 0;
        r6[0][0] = q14_of(c[3]*c[4]*c[5] - s[3]*s[5]*UNIT, 28);
        r6[0][1] = q14_of(-c[3]*c[4]*s[5] - s[3]*c[5]*UNIT, 28);
        r6[0][2] = q14_of(-c[3]*s[4], 14);
        r6[1][0] = q14_of(-s[4]*c[5], 14);
        r6[1][1] = q14_of(s[4]*s[5], 14);
        r6[1][2] = -c[4];
        r6[2][0] = q14_of(s[3]*c[4]*c[5] + c[3]*s[5]*UNIT, 28);
        r6[2][1] = q14_of(-s[3]*c[4]*s[5] + c[3]*c[5]*UNIT, 28);
        r6[2][2] = q14_of(-s[3]*s[4], 14);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += r3[i][k] * r6[k][j];
                tool[i][j] = q14_of(acc, 14);
                p.rot[3*i + j] = t_q14'(tool[i][j]);
            end
        px = c[0]*c[1]*link_len[REG_UPPER_ARM]
           + (c[0]*link_len[REG_SHOULDER_OFFSET] + s[0]*link_len[REG_LATERAL]) * UNIT
           - r3[0][1]*link_len[REG_FOREARM]*UNIT + tool[0][2]*link_len[REG_CLAW]*UNIT;
        py = s[0]*c[1]*link_len[REG_UPPER_ARM]
           + (s[0]*link_len[REG_SHOULDER_OFFSET] - c[0]*link_len[REG_LATERAL]) * UNIT
           - r3[1][1]*link_len[REG_FOREARM]*UNIT + tool[1][2]*link_len[REG_CLAW]*UNIT;
        pz = s[1]*link_len[REG_UPPER_ARM]*UNIT - r3[2][1]*link_len[REG_FOREARM]*UNIT
           + tool[2][2]*link_len[REG_CLAW]*UNIT + link_len[REG_BASE_HEIGHT]*UNIT*UNIT;
        p.tip_x = POS_W'(pos_of(px));
        p.tip_y = POS_W'(pos_of(py));
        p.tip_z = POS_W'(pos_of(pz));
        return p;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] word %0d %s: got %0d, want %0d", $time, word_cnt, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        word_cnt = 0;
        foreach (link_len[i]) link_len[i] = 0;
    end

    always @(posedge i_clk) begin
        t_pose got, want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr[4:2] <= 3'd5)
                link_len[paddr[4:2]] = longint'($signed(pwdata[19:0]));
            if (s_axis_tvalid && s_axis_tready) pose_q.push_back(tool_pose(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pose_q.size() == 0) begin
                    $display("[%0t] unexpected output word", $time);
                    o_errors++;
                end else begin
                    want = pose_q.pop_front();
                    if (got.tip_x != want.tip_x) report_mismatch("tip_x", got.tip_x, want.tip_x);
                    if (got.tip_y != want.tip_y) report_mismatch("tip_y", got.tip_y, want.tip_y);
                    if (got.tip_z != want.tip_z) report_mismatch("tip_z", got.tip_z, want.tip_z);
                    for (int k = 0; k < NUM_ROT; k++)
                        if (got.rot[k] != want.rot[k])
                            report_mismatch($sformatf("rot_%0d%0d", k / 3, k % 3),
                                            got.rot[k], want.rot[k]);
                end
                word_cnt++;
            end
        end
        o_pending = pose_q.size();
    end

endmodule

// ===== dv/tb_arm_forward_kinematics_core.sv =====
`timescale 1ns / 100ps

module tb_arm_forward_kinematics_core;
    import afk_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [215:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           errors;
    int           pending;
    int           idle_cycles;
    int           stall_left;
    bit           no_idle;

    arm_forward_kinematics_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    arm_forward_kinematics_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(0, 3))
            0: return 16'(16384 * $urandom_range(0, 3) + $urandom_range(0, 6) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    // hold output ready low for random stretches
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [4:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_word(input logic [95:0] angles);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= angles;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // mode 0 random, 1 all max, 2 all min, other modes write raw random words
    task automatic set_links(input int mode);
        logic [31:0] v;
        for (int r = 0; r < 8; r++) begin
            v = $urandom;
            if (mode == 1) v[19:0] = 20'h7FFFF;
            if (mode == 2) v[19:0] = 20'h80000;
            if (mode == 0 && $urandom_range(0, 3) == 0) v[19:0] = $urandom_range(0, 1) ?
                20'h7FFFF : 20'h80000;
            if (mode == 0 && $urandom_range(0, 1) == 0) v[19:0] = 20'($signed(v[13:0]));
            apb_write(5'(4 * r), v);
        end
    endtask

    task automatic random_phase(input int n);
        logic [95:0] w;
        for (int k = 0; k < n; k++) begin
            if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            for (int j = 0; j < NUM_JOINTS; j++) w[16*j +: 16] = pick_angle();
            send_word(w);
        end
        no_idle = 0;
        drain();
    endtask

    initial begin
        logic [15:0] special [10];
        logic [95:0] w;
        special = '{16'd0, 16'd16384, 16'd16385, 16'd32767, 16'd32768,
                    16'd49151, 16'd49152, 16'd65535, 16'd8192, 16'd16383};
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        no_idle = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < 10; k++) begin
            for (int j = 0; j < NUM_JOINTS; j++) w[16*j +: 16] = special[(k + 3 * j) % 10];
            send_word(w);
        end
        drain();
        set_links(1);
        for (int k = 0; k < 10; k++) begin
            for (int j = 0; j < NUM_JOINTS; j++) w[16*j +: 16] = special[(7 * k + j) % 10];
            send_word(w);
        end
        send_word('0);
        send_word('1);
        drain();

        random_phase(150);
        set_links(2);
        random_phase(150);
        set_links(0);
        random_phase(150);
        set_links(0);
        random_phase(150);
        set_links(1);
        random_phase(130);

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
